[rtl/gds_pkg.sv]
// Shared types, constants and the angle table for the gradient-direction stream.
package gds_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam int XY_W   = 32;
    localparam int Z_W    = 34;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 64;

    localparam int CODE_SHIFT  = 128;
    localparam int CODE_SCALE  = 40;
    localparam int TWO_PI_Q20  = 6588397;
    localparam longint ANGLE_MUL = longint'(CODE_SCALE) * longint'(TWO_PI_Q20);
    localparam longint ROUND_ADD = (longint'(CODE_SHIFT) << 52) + (longint'(1) << 51);

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [11:0] column;
        logic [15:0] row;
        logic        last_of_run;
        logic        frame_done;
        logic        zero;
    } tag_t;

    typedef struct packed {
        logic                   valid;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        tag_t                   tag;
    } cell_t;

    typedef struct packed {
        logic [7:0] angle_code;
        tag_t       tag;
    } result_t;

    function automatic logic signed [Z_W-1:0] step_angle(input int unsigned i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = 34'sh020000000;
            1:       a = 34'sh012E4051E;
            2:       a = 34'sh009FB385B;
            3:       a = 34'sh0051111D4;
            4:       a = 34'sh0028B0D43;
            5:       a = 34'sh00145D7E1;
            6:       a = 34'sh000A2F61E;
            7:       a = 34'sh000517C55;
            8:       a = 34'sh00028BE53;
            9:       a = 34'sh000145F2F;
            10:      a = 34'sh0000A2F98;
            11:      a = 34'sh0000517CC;
            12:      a = 34'sh000028BE6;
            13:      a = 34'sh0000145F3;
            14:      a = 34'sh00000A2FA;
            15:      a = 34'sh00000517D;
            16:      a = 34'sh0000028BE;
            17:      a = 34'sh00000145F;
            18:      a = 34'sh000000A30;
            19:      a = 34'sh000000518;
            20:      a = 34'sh00000028C;
            21:      a = 34'sh000000146;
            22:      a = 34'sh0000000A3;
            23:      a = 34'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/gradient_direction_stream.sv]
// Top level: pixel windowing, job issue, CORDIC cell chain, code scaling, result queue.
//
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+-------------------------
//  input    | s_valid s_ready s_pixel                 | raster-order pixels
//  result   | m_valid m_ready m_angle_code m_column   | direction codes with
//           | m_row m_last_of_run m_frame_done        | coordinates
//  config   | cfg_wr_en cfg_index cfg_data            | image width / height
//
// A pixel is taken only when every earlier result has left the queue; it then
// issues 0 to 4 jobs, one per cycle, into a chain of CORDIC_STEPS cells, two
// scaling stages and the queue. With a ready result channel, the next pixel is
// taken once the last result of a pixel with jobs has left the queue; after a
// pixel without jobs, once the issue state has returned to idle.
// A stalled result channel holds the queue and blocks new pixels. Reset and a write
// to the width or height register restart the frame at pixel (0,0).
module gradient_direction_stream #(
    parameter int MAX_WIDTH    = gds_pkg::MAX_WIDTH_DEF,
    parameter int CORDIC_STEPS = gds_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_angle_code,
    output logic [11:0] m_column,
    output logic [15:0] m_row,
    output logic        m_last_of_run,
    output logic        m_frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NJ = 4;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [CW-1:0] col_reg;
    logic [15:0] row_reg;
    logic [15:0] left_reg;
    logic [15:0] abl_reg;
    logic [15:0] above;
    logic [CW:0] w_eff;
    logic [15:0] h_eff;

    logic signed [gds_pkg::DIFF_W-1:0] job_dx_reg [NJ];
    logic signed [gds_pkg::DIFF_W-1:0] job_dy_reg [NJ];
    gds_pkg::tag_t                     job_tag_reg [NJ];
    logic signed [gds_pkg::DIFF_W-1:0] job_dx_next [NJ];
    logic signed [gds_pkg::DIFF_W-1:0] job_dy_next [NJ];
    gds_pkg::tag_t                     job_tag_next [NJ];
    logic [2:0] job_cnt_reg, job_cnt_next;
    logic [2:0] job_idx_reg;
    logic [2:0] occ_reg;

    logic in_acc, out_acc;
    logic signed [gds_pkg::DIFF_W-1:0] d_pl, d_ll, d_pa, d_aa;
    logic [11:0] col12;
    logic        fd_r0, fd_r1;

    gds_pkg::cell_t chain [CORDIC_STEPS+1];
    gds_pkg::cell_t issue_next;
    logic           res_valid;
    gds_pkg::result_t res;

    gds_pkg::result_t fifo [NJ];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fifo_cnt_reg;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;
    assign s_ready = (state_reg == ST_IDLE) && (occ_reg == 3'd0);

    always_comb begin
        if (width_reg < 13'd2) begin
            w_eff = (CW+1)'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(width_reg);
        end
        h_eff = (height_reg < 16'd2) ? 16'd2 : height_reg;
    end

    gds_linebuf #(.DEPTH(MAX_WIDTH)) u_linebuf (
        .aclk    (aclk),
        .wr_en   (in_acc),
        .wr_addr (col_reg),
        .wr_data (s_pixel),
        .rd_addr (col_reg),
        .rd_data (above)
    );

    // Differences, 17-bit signed.
    assign d_pl = gds_pkg::DIFF_W'({1'b0, s_pixel}) - gds_pkg::DIFF_W'({1'b0, left_reg});
    assign d_ll = gds_pkg::DIFF_W'({1'b0, left_reg}) - gds_pkg::DIFF_W'({1'b0, abl_reg});
    assign d_pa = gds_pkg::DIFF_W'({1'b0, s_pixel}) - gds_pkg::DIFF_W'({1'b0, above});
    assign d_aa = gds_pkg::DIFF_W'({1'b0, above}) - gds_pkg::DIFF_W'({1'b0, abl_reg});
    assign col12    = 12'(col_reg);
    assign fd_r0 = 1'b0;
    assign fd_r1 = (row_reg == h_eff - 16'd1) && ((CW+1)'(col_reg) == w_eff - (CW+1)'(1));

    // Build the jobs one pixel causes, in emission order.
    always_comb begin
        logic [2:0] n;
        gds_pkg::tag_t t;
        n = 3'd0;
        for (int k = 0; k < NJ; k++) begin
            job_dx_next[k]  = job_dx_reg[k];
            job_dy_next[k]  = job_dy_reg[k];
            job_tag_next[k] = job_tag_reg[k];
        end
        t = '0;
        if (row_reg != 16'd0 && col_reg == CW'(1)) begin
            if (row_reg == 16'd1) begin
                t.column = 12'd0; t.row = 16'd0; t.frame_done = fd_r0;
                t.zero = (d_aa == 0) && (d_ll == 0);
                job_dx_next[n[1:0]] = d_aa; job_dy_next[n[1:0]] = d_ll;
                job_tag_next[n[1:0]] = t; n = n + 3'd1;
                t.column = 12'd1; t.zero = (d_aa == 0) && (d_pa == 0);
                job_dx_next[n[1:0]] = d_aa; job_dy_next[n[1:0]] = d_pa;
                job_tag_next[n[1:0]] = t; n = n + 3'd1;
            end
            t.column = 12'd0; t.row = row_reg; t.frame_done = 1'b0;
            t.zero = (d_pl == 0) && (d_ll == 0);
            job_dx_next[n[1:0]] = d_pl; job_dy_next[n[1:0]] = d_ll;
            job_tag_next[n[1:0]] = t; n = n + 3'd1;
            t.column = 12'd1; t.frame_done = fd_r1;
            t.zero = (d_pl == 0) && (d_pa == 0);
            job_dx_next[n[1:0]] = d_pl; job_dy_next[n[1:0]] = d_pa;
            job_tag_next[n[1:0]] = t; n = n + 3'd1;
        end else if (row_reg != 16'd0 && col_reg >= CW'(2)) begin
            if (row_reg == 16'd1) begin
                t.column = col12; t.row = 16'd0; t.frame_done = fd_r0;
                t.zero = (d_aa == 0) && (d_pa == 0);
                job_dx_next[n[1:0]] = d_aa; job_dy_next[n[1:0]] = d_pa;
                job_tag_next[n[1:0]] = t; n = n + 3'd1;
            end
            t.column = col12; t.row = row_reg; t.frame_done = fd_r1;
            t.zero = (d_pl == 0) && (d_pa == 0);
            job_dx_next[n[1:0]] = d_pl; job_dy_next[n[1:0]] = d_pa;
            job_tag_next[n[1:0]] = t; n = n + 3'd1;
        end
        job_cnt_next = n;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (job_idx_reg + 3'd1 >= job_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // Pass through the issue state so the line buffer can read the restarted address.
        if (cfg_wr_en) begin
            state_next = ST_ISSUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ISSUE;
            width_reg   <= 13'd640;
            height_reg  <= 16'd480;
            col_reg     <= '0;
            row_reg     <= '0;
            left_reg    <= '0;
            abl_reg     <= '0;
            job_cnt_reg <= '0;
            job_idx_reg <= '0;
            occ_reg     <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_reg + (in_acc ? job_cnt_next : 3'd0) - (out_acc ? 3'd1 : 3'd0);
            if (in_acc) begin
                job_cnt_reg <= job_cnt_next;
                job_idx_reg <= '0;
                abl_reg     <= above;
                left_reg    <= s_pixel;
                if ((CW+1)'(col_reg) + (CW+1)'(1) >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (row_reg + 16'd1 >= h_eff) ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end else if (state_reg == ST_ISSUE) begin
                job_idx_reg <= job_idx_reg + 3'd1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gds_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_data[12:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    gds_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default: begin
                    end
                endcase
                job_cnt_reg <= '0;
                job_idx_reg <= '0;
            end
        end
        if (in_acc) begin
            for (int k = 0; k < NJ; k++) begin
                job_dx_reg[k]  <= job_dx_next[k];
                job_dy_reg[k]  <= job_dy_next[k];
                job_tag_reg[k] <= job_tag_next[k];
            end
        end
    end

    // Issue stage: fold the left half-plane, then feed cell 0.
    always_comb begin
        logic signed [gds_pkg::XY_W-1:0] dx_s, dy_s;
        logic [1:0] idx;
        idx  = job_idx_reg[1:0];
        dx_s = gds_pkg::XY_W'(job_dx_reg[idx]) <<< 12;
        dy_s = gds_pkg::XY_W'(job_dy_reg[idx]) <<< 12;
        issue_next.valid = (state_reg == ST_ISSUE) && (job_idx_reg < job_cnt_reg);
        issue_next.tag   = job_tag_reg[idx];
        issue_next.tag.last_of_run = (job_idx_reg + 3'd1 == job_cnt_reg);
        if (job_dx_reg[idx] < 0) begin
            issue_next.x = -dx_s;
            issue_next.y = -dy_s;
            issue_next.z = (job_dy_reg[idx] >= 0) ? (gds_pkg::Z_W'(1) <<< 31)
                                                  : -(gds_pkg::Z_W'(1) <<< 31);
        end else begin
            issue_next.x = dx_s;
            issue_next.y = dy_s;
            issue_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain[0].valid <= 1'b0;
        end else begin
            chain[0].valid <= issue_next.valid;
        end
        chain[0].x   <= issue_next.x;
        chain[0].y   <= issue_next.y;
        chain[0].z   <= issue_next.z;
        chain[0].tag <= issue_next.tag;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        gds_cell #(.STEP(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    gds_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cell_in   (chain[CORDIC_STEPS]),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue; occupancy accounting keeps it from overflowing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (out_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + (res_valid ? 3'd1 : 3'd0) - (out_acc ? 3'd1 : 3'd0);
        end
        if (res_valid) begin
            fifo[wr_ptr_reg] <= res;
        end
    end

    assign m_valid       = (fifo_cnt_reg != 3'd0);
    assign m_angle_code  = fifo[rd_ptr_reg].angle_code;
    assign m_column      = fifo[rd_ptr_reg].tag.column;
    assign m_row         = fifo[rd_ptr_reg].tag.row;
    assign m_last_of_run = fifo[rd_ptr_reg].tag.last_of_run;
    assign m_frame_done  = fifo[rd_ptr_reg].tag.frame_done;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 3'd4)
        else $error("outstanding results exceed queue depth");
    a_queue_le_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= occ_reg)
        else $error("queue holds more than outstanding results");
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("pixel accepted back to back");
`endif

endmodule

[rtl/gds_linebuf.sv]
// Line buffer holding the previous image row, registered read.
module gds_linebuf #(
    parameter int DEPTH = gds_pkg::MAX_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [15:0]              rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/gds_cell.sv]
// One CORDIC vectoring step; hands its vector to the next cell every cycle.
module gds_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  gds_pkg::cell_t cell_in,
    output gds_pkg::cell_t cell_out
);

    gds_pkg::cell_t cell_reg;
    gds_pkg::cell_t cell_next;
    logic signed [gds_pkg::XY_W-1:0] x_sh;
    logic signed [gds_pkg::XY_W-1:0] y_sh;

    assign x_sh = cell_in.x >>> STEP;
    assign y_sh = cell_in.y >>> STEP;

    always_comb begin
        cell_next = cell_in;
        if (cell_in.y >= 0) begin
            cell_next.x = cell_in.x + y_sh;
            cell_next.y = cell_in.y - x_sh;
            cell_next.z = cell_in.z + gds_pkg::step_angle(STEP);
        end else begin
            cell_next.x = cell_in.x - y_sh;
            cell_next.y = cell_in.y + x_sh;
            cell_next.z = cell_in.z - gds_pkg::step_angle(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_in.valid;
        end
        cell_reg.x   <= cell_next.x;
        cell_reg.y   <= cell_next.y;
        cell_reg.z   <= cell_next.z;
        cell_reg.tag <= cell_next.tag;
    end

    assign cell_out = cell_reg;

endmodule

[rtl/gds_angle.sv]
// Scales the final CORDIC angle to the 8-bit direction code with rounding and clamp.
module gds_angle (
    input  logic             aclk,
    input  logic             aresetn,
    input  gds_pkg::cell_t   cell_in,
    output logic             res_valid,
    output gds_pkg::result_t res
);

    logic                                valid_a_reg;
    logic signed [gds_pkg::PROD_W-1:0]   prod_reg;
    gds_pkg::tag_t                       tag_a_reg;
    logic                                valid_b_reg;
    gds_pkg::result_t                    res_reg;
    logic signed [gds_pkg::PROD_W-1:0]   t_sum;
    logic signed [gds_pkg::PROD_W-1:0]   t_shift;
    logic [7:0]                          code_next;

    always_comb begin
        t_sum   = prod_reg + gds_pkg::ROUND_ADD;
        t_shift = t_sum >>> 52;
        if (tag_a_reg.zero) begin
            code_next = 8'(gds_pkg::CODE_SHIFT);
        end else if (t_sum < 0) begin
            code_next = 8'd0;
        end else if (t_shift > 255) begin
            code_next = 8'd255;
        end else begin
            code_next = t_shift[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_a_reg <= cell_in.valid;
            valid_b_reg <= valid_a_reg;
        end
        prod_reg           <= gds_pkg::PROD_W'(cell_in.z) * gds_pkg::ANGLE_MUL;
        tag_a_reg          <= cell_in.tag;
        res_reg.angle_code <= code_next;
        res_reg.tag        <= tag_a_reg;
    end

    assign res_valid = valid_b_reg;
    assign res       = res_reg;

endmodule
